### hdl/msc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msc_pkg;

   // Lane count of one transfer, message and magnitude widths
   localparam int LANE_FIELDS = 12;
   localparam int MSG_W       = 8;
   localparam int MAG_W       = 7;

   // Largest scaled magnitude (128 -> 104, 127 -> 105)
   localparam logic [MAG_W-1:0] MAG_MAX      = 7'd105;
   // Magnitude given to lanes that take no part; above any real value
   localparam logic [MAG_W-1:0] MAG_INACTIVE = 7'd127;

   typedef logic signed [MSG_W-1:0] msg_type;
   typedef logic [MAG_W-1:0]        mag_type;

   // Input transfer: msg_0 sits in the low byte
   typedef struct packed {
      msg_type msg_11;
      msg_type msg_10;
      msg_type msg_9;
      msg_type msg_8;
      msg_type msg_7;
      msg_type msg_6;
      msg_type msg_5;
      msg_type msg_4;
      msg_type msg_3;
      msg_type msg_2;
      msg_type msg_1;
      msg_type msg_0;
   } req_type;

   // Result transfer: ext_0 sits in the low byte
   typedef struct packed {
      msg_type ext_11;
      msg_type ext_10;
      msg_type ext_9;
      msg_type ext_8;
      msg_type ext_7;
      msg_type ext_6;
      msg_type ext_5;
      msg_type ext_4;
      msg_type ext_3;
      msg_type ext_2;
      msg_type ext_1;
      msg_type ext_0;
   } rsp_type;

   // Smallest and second smallest of a group
   typedef struct packed {
      mag_type min1;
      mag_type min2;
   } two_min_type;

   // After the magnitude stage
   typedef struct packed {
      logic    [LANE_FIELDS-1:0] neg;
      mag_type [LANE_FIELDS-1:0] mag;
   } mag_stage_type;

   // After the first tree stage: three partial two-minimums
   typedef struct packed {
      two_min_type [2:0]             part;
      logic                          parity;
      logic        [LANE_FIELDS-1:0] neg;
      mag_type     [LANE_FIELDS-1:0] mag;
   } part_stage_type;

   // After the second tree stage: the row's two-minimum
   typedef struct packed {
      two_min_type                   best;
      logic                          parity;
      logic        [LANE_FIELDS-1:0] neg;
      mag_type     [LANE_FIELDS-1:0] mag;
   } tree_stage_type;

   // m - m/8 - m/16 for m in 0..128
   function automatic mag_type scale_mag(logic [MSG_W-1:0] m);
      logic [MSG_W-1:0] r;
      r = m - (m >> 3) - (m >> 4);
      return r[MAG_W-1:0];
   endfunction

   // Pairwise sort of two magnitudes
   function automatic two_min_type sort_pair(mag_type a, mag_type b);
      two_min_type r;
      if (a <= b) begin
         r.min1 = a;
         r.min2 = b;
      end else begin
         r.min1 = b;
         r.min2 = a;
      end
      return r;
   endfunction

   // Merge two two-minimums; equal values count as separate entries
   function automatic two_min_type merge_min(two_min_type a, two_min_type b);
      two_min_type r;
      if (a.min1 <= b.min1) begin
         r.min1 = a.min1;
         r.min2 = (a.min2 <= b.min1) ? a.min2 : b.min1;
      end else begin
         r.min1 = b.min1;
         r.min2 = (a.min1 <= b.min2) ? a.min1 : b.min2;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/msc_mag_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module msc_mag_stage import msc_pkg::*; #(
   parameter int NUM_LANES = 12
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output      logic                      in_ready,
   input  wire msg_type [LANE_FIELDS-1:0] in_msg,
   output      logic                      out_valid,
   input  wire logic                      out_ready,
   output      mag_stage_type             out_data
);

   logic          valid_ff;
   mag_stage_type data_ff;
   mag_stage_type data_in;

   // Sign split, absolute value and 13/16 scaling per lane
   always_comb begin
      logic [MSG_W-1:0] m;
      for (int i = 0; i < LANE_FIELDS; i++) begin
         m = in_msg[i][MSG_W-1] ? MSG_W'(~in_msg[i] + 1'b1) : in_msg[i];
         if (i < NUM_LANES) begin
            data_in.neg[i] = in_msg[i][MSG_W-1];
            data_in.mag[i] = scale_mag(m);
         end else begin
            data_in.neg[i] = 1'b0;
            data_in.mag[i] = MAG_INACTIVE;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

### hdl/msc_min_tree.sv
`timescale 1ns / 1ps
`default_nettype none

module msc_min_tree import msc_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output      logic           in_ready,
   input  wire mag_stage_type  in_data,
   output      logic           out_valid,
   input  wire logic           out_ready,
   output      tree_stage_type out_data
);

   logic           valid_b_ff;
   part_stage_type part_b_ff;
   part_stage_type part_b_in;
   logic           ready_b;

   logic           valid_c_ff;
   tree_stage_type tree_c_ff;
   tree_stage_type tree_c_in;
   logic           ready_c;

   // Stage B: sort six pairs, merge them into three groups of four
   always_comb begin
      two_min_type [LANE_FIELDS/2-1:0] pair;
      for (int k = 0; k < LANE_FIELDS/2; k++) begin
         pair[k] = sort_pair(in_data.mag[2*k], in_data.mag[2*k+1]);
      end
      for (int j = 0; j < 3; j++) begin
         part_b_in.part[j] = merge_min(pair[2*j], pair[2*j+1]);
      end
      part_b_in.parity = ^in_data.neg;
      part_b_in.neg    = in_data.neg;
      part_b_in.mag    = in_data.mag;
   end

   // Stage C: merge the three groups
   always_comb begin
      tree_c_in.best   = merge_min(merge_min(part_b_ff.part[0], part_b_ff.part[1]),
                                   part_b_ff.part[2]);
      tree_c_in.parity = part_b_ff.parity;
      tree_c_in.neg    = part_b_ff.neg;
      tree_c_in.mag    = part_b_ff.mag;
   end

   assign ready_c  = !valid_c_ff || out_ready;
   assign ready_b  = !valid_b_ff || ready_c;
   assign in_ready = ready_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         if (ready_b) begin
            valid_b_ff <= in_valid;
         end
         if (ready_c) begin
            valid_c_ff <= valid_b_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready_b) begin
         part_b_ff <= part_b_in;
      end
      if (valid_b_ff && ready_c) begin
         tree_c_ff <= tree_c_in;
      end
   end

   assign out_valid = valid_c_ff;
   assign out_data  = tree_c_ff;

   // Minimums come out ordered; each is a scaled value or the idle-lane marker
   a_min_order: assert property (@(posedge clock) disable iff (reset)
      valid_c_ff |-> tree_c_ff.best.min1 <= tree_c_ff.best.min2)
      else $error("min tree: first minimum above second");

   a_min_range: assert property (@(posedge clock) disable iff (reset)
      valid_c_ff |-> (tree_c_ff.best.min2 <= MAG_MAX ||
                      tree_c_ff.best.min2 == MAG_INACTIVE))
      else $error("min tree: second minimum out of range");

   // First partial group comes out ordered
   a_part_order: assert property (@(posedge clock) disable iff (reset)
      valid_b_ff |-> part_b_ff.part[0].min1 <= part_b_ff.part[0].min2)
      else $error("min tree: partial group out of order");

endmodule

`default_nettype wire

### hdl/msc_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module msc_out_stage import msc_pkg::*; #(
   parameter int NUM_LANES = 12
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output      logic           in_ready,
   input  wire tree_stage_type in_data,
   output      logic           out_valid,
   input  wire logic           out_ready,
   output      rsp_type        out_data
);

   logic                      valid_ff;
   msg_type [LANE_FIELDS-1:0] ext_ff;
   msg_type [LANE_FIELDS-1:0] ext_in;

   // Per lane: pick the other minimum on a match, apply extrinsic sign
   always_comb begin
      mag_type          lo1;
      mag_type          lo2;
      mag_type          m;
      logic [MSG_W-1:0] wide;
      // With fewer than two active lanes the idle marker wins; it reads as 0
      lo1 = (in_data.best.min1 > MAG_MAX) ? '0 : in_data.best.min1;
      lo2 = (in_data.best.min2 > MAG_MAX) ? '0 : in_data.best.min2;
      for (int i = 0; i < LANE_FIELDS; i++) begin
         m    = (in_data.mag[i] == lo1) ? lo2 : lo1;
         wide = {1'b0, m};
         if (i < NUM_LANES) begin
            ext_in[i] = (in_data.parity ^ in_data.neg[i]) ? MSG_W'(~wide + 1'b1) : wide;
         end else begin
            ext_in[i] = '0;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         ext_ff <= ext_in;
      end
   end

   assign out_valid       = valid_ff;
   assign out_data.ext_0  = ext_ff[0];
   assign out_data.ext_1  = ext_ff[1];
   assign out_data.ext_2  = ext_ff[2];
   assign out_data.ext_3  = ext_ff[3];
   assign out_data.ext_4  = ext_ff[4];
   assign out_data.ext_5  = ext_ff[5];
   assign out_data.ext_6  = ext_ff[6];
   assign out_data.ext_7  = ext_ff[7];
   assign out_data.ext_8  = ext_ff[8];
   assign out_data.ext_9  = ext_ff[9];
   assign out_data.ext_10 = ext_ff[10];
   assign out_data.ext_11 = ext_ff[11];

   // Lane 0 is always active; its answer stays within the scaled range
   a_lane0_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (ext_ff[0] <= 8'sd105 && ext_ff[0] >= -8'sd105))
      else $error("out stage: lane 0 result out of range");

endmodule

`default_nettype wire

### hdl/min_sum_check_node_update_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Normalized min-sum LDPC check-node update. Each transfer on req_ carries
// twelve signed 8-bit variable-to-check messages; each transfer on rsp_
// returns twelve extrinsic messages in -105..105. Magnitudes are scaled by
// 13/16, the two smallest are found, and every lane gets the minimum of the
// others with the sign product of the other lanes. Lanes at or above
// NUM_LANES are ignored and answer 0. The unit accepts one transfer every
// cycle while it is not stalled; results pass through the magnitude stage,
// two min-tree stages and the output register, and back-pressure on rsp_
// stalls the pipeline without losing or repeating data.
module min_sum_check_node_update_unit import msc_pkg::*; #(
   parameter int NUM_LANES = 12
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   msg_type [LANE_FIELDS-1:0] req_msg;
   logic                      mag_valid;
   logic                      mag_ready;
   mag_stage_type             mag_data;
   logic                      tree_valid;
   logic                      tree_ready;
   tree_stage_type            tree_data;

   // Unpack the request into a lane array
   assign req_msg[0]  = req_data.msg_0;
   assign req_msg[1]  = req_data.msg_1;
   assign req_msg[2]  = req_data.msg_2;
   assign req_msg[3]  = req_data.msg_3;
   assign req_msg[4]  = req_data.msg_4;
   assign req_msg[5]  = req_data.msg_5;
   assign req_msg[6]  = req_data.msg_6;
   assign req_msg[7]  = req_data.msg_7;
   assign req_msg[8]  = req_data.msg_8;
   assign req_msg[9]  = req_data.msg_9;
   assign req_msg[10] = req_data.msg_10;
   assign req_msg[11] = req_data.msg_11;

   msc_mag_stage #(
      .NUM_LANES (NUM_LANES)
   ) u_mag (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_msg    (req_msg),
      .out_valid (mag_valid),
      .out_ready (mag_ready),
      .out_data  (mag_data)
   );

   msc_min_tree u_tree (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mag_valid),
      .in_ready  (mag_ready),
      .in_data   (mag_data),
      .out_valid (tree_valid),
      .out_ready (tree_ready),
      .out_data  (tree_data)
   );

   msc_out_stage #(
      .NUM_LANES (NUM_LANES)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tree_valid),
      .in_ready  (tree_ready),
      .in_data   (tree_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

### tb/min_sum_check_node_update_unit_tb.sv
`timescale 1ns / 1ps

module min_sum_check_node_update_unit_tb;
   import msc_pkg::*;

   localparam int ACTIVE_LANES = 12;
   localparam int DIR_ROWS     = 16;
   localparam int RAND_ROWS    = 1950;

   typedef logic [LANE_FIELDS-1:0][MSG_W-1:0] lane_vec_type;

   // One directed row: input messages, whether the answer is typed in, the answer
   typedef struct packed {
      req_type row;
      logic    known;
      rsp_type ext;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Extrinsic rows still owed by the unit, oldest first
   rsp_type exp_ext_q[$];
   int      fail_cnt = 0;
   int      req_gap_max = 4;
   int      rsp_stall_max = 4;

   // Directed rows; lane 11 is the leftmost byte
   dir_row_type dir_tbl [DIR_ROWS] = '{
      // all zero
      {{12{8'h00}}, 1'b1, {12{8'h00}}},
      // all most negative: 104 everywhere, eleven negative others
      {{12{8'h80}}, 1'b1, {12{8'h98}}},
      // all largest positive: 105 everywhere
      {{12{8'h7f}}, 1'b1, {12{8'h69}}},
      // all -1
      {{12{8'hff}}, 1'b1, {12{8'hff}}},
      // all +1
      {{12{8'h01}}, 1'b1, {12{8'h01}}},
      // one most negative among largest positives
      {{{11{8'h7f}}, 8'h80}, 1'b1, {{11{8'h98}}, 8'h69}},
      // zero with negative others: the others see a signed zero
      {{{11{8'hfb}}, 8'h00}, 1'b0, {12{8'h00}}},
      {{{11{8'h80}}, 8'h00}, 1'b0, {12{8'h00}}},
      // decoder padding on lanes 10 and 11
      {{8'h7f, 8'h7f, 8'h12, 8'hc4, 8'h33, 8'h9e, 8'h05, 8'hf0, 8'h21, 8'h80,
        8'h6a, 8'hd7}, 1'b0, {12{8'h00}}},
      // unique minimum in lane 5
      {{{6{8'h28}}, 8'h03, {5{8'h28}}}, 1'b0, {12{8'h00}}},
      // tied minimum in lanes 2 and 7
      {{8'h40, 8'hc0, 8'h40, 8'h84, 8'hf9, 8'h40, 8'h40, 8'h40, 8'hc0, 8'h07,
        8'h40, 8'hc0}, 1'b0, {12{8'h00}}},
      // alternating signs
      {{6{8'h10, 8'hf0}}, 1'b0, {12{8'h00}}},
      // ramp 1..12
      {{8'h0c, 8'h0b, 8'h0a, 8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03,
        8'h02, 8'h01}, 1'b0, {12{8'h00}}},
      // -127 against 127
      {{6{8'h81, 8'h7f}}, 1'b0, {12{8'h00}}},
      // scaling steps around 8 and 16
      {{8'h08, 8'hf8, 8'h10, 8'hf0, 8'h0f, 8'hf1, 8'h11, 8'h18, 8'he8, 8'h20,
        8'h07, 8'h09}, 1'b0, {12{8'h00}}},
      // bit patterns
      {{6{8'h55, 8'haa}}, 1'b0, {12{8'h00}}}
   };

   min_sum_check_node_update_unit #(
      .NUM_LANES(ACTIVE_LANES)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Normalized min-sum answer for one row of messages
   function automatic rsp_type check_node_ext(req_type row);
      lane_vec_type               in_l;
      lane_vec_type               out_l;
      logic [MSG_W:0]             m;
      logic [MSG_W-1:0]           sc [LANE_FIELDS];
      logic [LANE_FIELDS-1:0]     neg;
      logic [MSG_W-1:0]           lo1;
      logic [MSG_W-1:0]           lo2;
      logic [MSG_W-1:0]           pick;
      logic                       par;
      int                         n;
      in_l = lane_vec_type'(row);
      n    = (ACTIVE_LANES > LANE_FIELDS) ? LANE_FIELDS : ACTIVE_LANES;
      // magnitude scaled by 13/16
      for (int i = 0; i < LANE_FIELDS; i++) begin
         neg[i] = in_l[i][MSG_W-1];
         m      = neg[i] ? (9'd256 - in_l[i]) : {1'b0, in_l[i]};
         sc[i]  = MSG_W'(m - (m >> 3) - (m >> 4));
      end
      // two smallest over active lanes, ties kept apart
      lo1 = 8'hff;
      lo2 = 8'hff;
      par = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (sc[i] < lo1) begin
            lo2 = lo1;
            lo1 = sc[i];
         end else if (sc[i] < lo2) begin
            lo2 = sc[i];
         end
         par ^= neg[i];
      end
      if (lo1 > MAG_MAX) lo1 = '0;
      if (lo2 > MAG_MAX) lo2 = '0;
      // each lane: minimum of the others, sign of the others
      for (int i = 0; i < LANE_FIELDS; i++) begin
         out_l[i] = '0;
         if (i < n) begin
            pick     = (sc[i] == lo1) ? lo2 : lo1;
            out_l[i] = (par ^ neg[i]) ? (8'd0 - pick) : pick;
         end
      end
      return rsp_type'(out_l);
   endfunction

   // Random row: raw bytes, small magnitudes for ties, extremes, or padded
   function automatic req_type random_row();
      lane_vec_type l;
      int           kind;
      int           mag;
      kind = $urandom_range(0, 3);
      for (int i = 0; i < LANE_FIELDS; i++) begin
         mag = $urandom_range(0, 12);
         case (kind)
            0: begin
               l[i] = MSG_W'($urandom);
            end
            1: begin
               l[i] = $urandom_range(0, 1) ? MSG_W'(256 - mag) : MSG_W'(mag);
            end
            2: begin
               case ($urandom_range(0, 5))
                  0: l[i] = 8'h80;
                  1: l[i] = 8'h81;
                  2: l[i] = 8'hff;
                  3: l[i] = 8'h00;
                  4: l[i] = 8'h01;
                  default: l[i] = 8'h7f;
               endcase
            end
            default: begin
               l[i] = $urandom_range(0, 1) ? MSG_W'($urandom) : MSG_W'(256 - mag);
            end
         endcase
      end
      if (kind == 3) begin
         l[10] = 8'h7f;
         l[11] = 8'h7f;
      end
      return req_type'(l);
   endfunction

   // Offer one row after a random gap and hold it until the transfer
   task automatic send_row(req_type row, logic known, rsp_type typed);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= row;
      do @(posedge clock); while (req_ready !== 1'b1);
      exp_ext_q.push_back(known ? typed : check_node_ext(row));
   endtask

   // Stimulus and end of run
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tbl[k]) begin
         send_row(dir_tbl[k].row, dir_tbl[k].known, dir_tbl[k].ext);
      end

      for (int k = 0; k < RAND_ROWS; k++) begin
         // stretches with and without source gaps
         if (k % 64 == 0) req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
         send_row(random_row(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (exp_ext_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (fail_cnt == 0 && exp_ext_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Result side: random stalls, compare each transfer lane by lane
   initial begin : rsp_side
      int           stall;
      int           seen;
      lane_vec_type want_l;
      lane_vec_type got_l;
      rsp_ready = 1'b0;
      seen      = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (seen % 64 == 0) rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         seen++;
         got_l = lane_vec_type'(rsp_data);
         if (exp_ext_q.size() == 0) begin
            fail_cnt++;
            $display("%0t: result with nothing expected, got %h", $time, rsp_data);
         end else begin
            want_l = lane_vec_type'(exp_ext_q.pop_front());
            for (int i = 0; i < LANE_FIELDS; i++) begin
               if (got_l[i] !== want_l[i]) begin
                  fail_cnt++;
                  $display("%0t: ext_%0d expected %0d got %0d", $time, i,
                           $signed(want_l[i]), $signed(got_l[i]));
               end
            end
         end
      end
   end

   // Hang guard
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
